>>> hw/rtl/assert_macros.svh
// assertion macros used by the gradient unit rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property that must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// consequence that must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

>>> hw/rtl/rsg_pkg.sv
// types, constants and helpers shared by the gradient unit
package rsg_pkg;

    localparam int COLOR_W    = 16;
    localparam int CHAN_W     = 6;
    localparam int N_CHAN     = 3;
    localparam int NUM_W      = 22;
    localparam int Q_W        = 6;
    localparam int DIV_STAGES = 3;
    localparam int DIV_BITS   = 2;
    localparam int CFG_IDX_W  = 3;

    localparam int RED_SHIFT   = 11;
    localparam int GREEN_SHIFT = 5;
    localparam logic [COLOR_W-1:0] RED_MASK   = 16'h001F;
    localparam logic [COLOR_W-1:0] GREEN_MASK = 16'h003F;
    localparam logic [COLOR_W-1:0] BLUE_MASK  = 16'h001F;

    localparam int CH_RED   = 0;
    localparam int CH_GREEN = 1;
    localparam int CH_BLUE  = 2;

    localparam logic [15:0] RESET_RANGE_LOW  = 16'd0;
    localparam logic [15:0] RESET_RANGE_MID  = 16'd50;
    localparam logic [15:0] RESET_RANGE_HIGH = 16'd100;
    localparam logic [15:0] RESET_COLOR      = 16'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RANGE_LOW    = 3'd0,
        REG_RANGE_MID    = 3'd1,
        REG_RANGE_HIGH   = 3'd2,
        REG_COLOR_START  = 3'd3,
        REG_COLOR_MIDDLE = 3'd4,
        REG_COLOR_END    = 3'd5
    } reg_idx_t;

    typedef struct packed {
        logic [15:0] range_low;
        logic [15:0] range_mid;
        logic [15:0] range_high;
        logic [COLOR_W-1:0] color_start;
        logic [COLOR_W-1:0] color_middle;
        logic [COLOR_W-1:0] color_end;
    } cfg_t;

    // segment word: offset, width and the two end colors
    typedef struct packed {
        logic [15:0] n;
        logic [15:0] d;
        logic [COLOR_W-1:0] c1;
        logic [COLOR_W-1:0] c2;
    } seg_t;

    // blend numerators per channel and the divisor
    typedef struct packed {
        logic [N_CHAN-1:0][NUM_W-1:0] num;
        logic [15:0] d;
    } num_t;

    // divider word: partial remainder and quotient per channel
    typedef struct packed {
        logic [N_CHAN-1:0][NUM_W-1:0] rem;
        logic [N_CHAN-1:0][Q_W-1:0] q;
        logic [15:0] d;
    } div_t;

    function automatic logic [CHAN_W-1:0] chan_field(input logic [COLOR_W-1:0] c,
                                                     input int unsigned ch);
        logic [COLOR_W-1:0] f;
        case (ch)
            CH_RED:   f = (c >> RED_SHIFT) & RED_MASK;
            CH_GREEN: f = (c >> GREEN_SHIFT) & GREEN_MASK;
            default:  f = c & BLUE_MASK;
        endcase
        return f[CHAN_W-1:0];
    endfunction

endpackage

>>> hw/rtl/rsg_front.sv
// clamp and segment selection stages of the gradient unit
module rsg_front #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  rsg_pkg::cfg_t          cfg,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  logic [LEVEL_WIDTH-1:0] level,
    output logic                   seg_valid,
    input  logic                   seg_ready,
    output rsg_pkg::seg_t          seg
);

    localparam int CW = (LEVEL_WIDTH > 16) ? LEVEL_WIDTH : 16;

    logic                 v1_reg;
    logic [15:0]          lvl_reg;
    logic [15:0]          lvl_next;
    logic                 v2_reg;
    rsg_pkg::seg_t        seg_reg;
    rsg_pkg::seg_t        seg_next;
    logic                 rdy1;
    logic                 rdy2;

    logic signed [CW-1:0] level_w;
    logic signed [CW-1:0] lo_w;
    logic signed [CW-1:0] hi_w;

    logic                 lower;
    logic [15:0]          base;
    logic [15:0]          top_b;
    logic signed [16:0]   n17;
    logic signed [16:0]   d17;

    // stage handshake
    assign rdy2     = !v2_reg || seg_ready;
    assign rdy1     = !v1_reg || rdy2;
    assign in_ready = rdy1;

    // clamp the level to the low and high breakpoints
    assign level_w = CW'($signed(level));
    assign lo_w    = CW'($signed(cfg.range_low));
    assign hi_w    = CW'($signed(cfg.range_high));

    always_comb
    begin
        if (level_w < lo_w)
            lvl_next = cfg.range_low;
        else if (level_w > hi_w)
            lvl_next = cfg.range_high;
        else
            lvl_next = level_w[15:0];
    end

    // pick the segment, offset and width; saturate the offset
    always_comb
    begin
        lower = $signed(lvl_reg) <= $signed(cfg.range_mid);
        base  = lower ? cfg.range_low : cfg.range_mid;
        top_b = lower ? cfg.range_mid : cfg.range_high;
        n17   = 17'($signed(lvl_reg)) - 17'($signed(base));
        d17   = 17'($signed(top_b)) - 17'($signed(base));
        seg_next.c1 = lower ? cfg.color_start  : cfg.color_middle;
        seg_next.c2 = lower ? cfg.color_middle : cfg.color_end;
        if (d17 <= 17'sd0)
        begin
            // empty or reversed segment: n/d = 0/1 yields the first color
            seg_next.n = 16'd0;
            seg_next.d = 16'd1;
        end
        else
        begin
            seg_next.d = d17[15:0];
            if (n17 < 17'sd0)
                seg_next.n = 16'd0;
            else if (n17 > d17)
                seg_next.n = d17[15:0];
            else
                seg_next.n = n17[15:0];
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
        end
        else
        begin
            if (rdy1)
                v1_reg <= in_valid;
            if (rdy2)
                v2_reg <= v1_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rdy1 && in_valid)
            lvl_reg <= lvl_next;
        if (rdy2 && v1_reg)
            seg_reg <= seg_next;
    end

    assign seg_valid = v2_reg;
    assign seg       = seg_reg;

endmodule

>>> hw/rtl/rsg_mac.sv
// weighted sum stages: per channel c1*(d-n) + c2*n
module rsg_mac (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          seg_valid,
    output logic          seg_ready,
    input  rsg_pkg::seg_t seg,
    output logic          num_valid,
    input  logic          num_ready,
    output rsg_pkg::num_t num
);

    logic                                                 v3_reg;
    logic [rsg_pkg::N_CHAN-1:0][rsg_pkg::NUM_W-1:0]       prod_a_reg;
    logic [rsg_pkg::N_CHAN-1:0][rsg_pkg::NUM_W-1:0]       prod_b_reg;
    logic [rsg_pkg::N_CHAN-1:0][rsg_pkg::NUM_W-1:0]       prod_a_next;
    logic [rsg_pkg::N_CHAN-1:0][rsg_pkg::NUM_W-1:0]       prod_b_next;
    logic [15:0]                                          d3_reg;
    logic                                                 v4_reg;
    rsg_pkg::num_t                                        num_reg;
    rsg_pkg::num_t                                        num_next;
    logic [15:0]                                          w;
    logic                                                 rdy3;
    logic                                                 rdy4;

    // stage handshake
    assign rdy4      = !v4_reg || num_ready;
    assign rdy3      = !v3_reg || rdy4;
    assign seg_ready = rdy3;

    // products, one small multiplier per term
    assign w = seg.d - seg.n;

    always_comb
    begin
        for (int ch = 0; ch < rsg_pkg::N_CHAN; ch++)
        begin
            prod_a_next[ch] = rsg_pkg::NUM_W'(rsg_pkg::chan_field(seg.c1, ch))
                            * rsg_pkg::NUM_W'(w);
            prod_b_next[ch] = rsg_pkg::NUM_W'(rsg_pkg::chan_field(seg.c2, ch))
                            * rsg_pkg::NUM_W'(seg.n);
        end
    end

    // sum of the two terms, never above 63 * 65535
    always_comb
    begin
        for (int ch = 0; ch < rsg_pkg::N_CHAN; ch++)
            num_next.num[ch] = prod_a_reg[ch] + prod_b_reg[ch];
        num_next.d = d3_reg;
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (rdy3)
                v3_reg <= seg_valid;
            if (rdy4)
                v4_reg <= v3_reg;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (rdy3 && seg_valid)
        begin
            prod_a_reg <= prod_a_next;
            prod_b_reg <= prod_b_next;
            d3_reg     <= seg.d;
        end
        if (rdy4 && v3_reg)
            num_reg <= num_next;
    end

    assign num_valid = v4_reg;
    assign num       = num_reg;

endmodule

>>> hw/rtl/rsg_div.sv
// pipelined restoring divider, two quotient bits per stage
`include "assert_macros.svh"

module rsg_div (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          num_valid,
    output logic          num_ready,
    input  rsg_pkg::num_t num,
    output logic          res_valid,
    input  logic          res_ready,
    output rsg_pkg::div_t res
);

    localparam int LAST = rsg_pkg::DIV_STAGES - 1;

    logic          v_reg   [rsg_pkg::DIV_STAGES];
    rsg_pkg::div_t st_reg  [rsg_pkg::DIV_STAGES];
    rsg_pkg::div_t st_next [rsg_pkg::DIV_STAGES];
    rsg_pkg::div_t st_in   [rsg_pkg::DIV_STAGES];
    logic          v_in    [rsg_pkg::DIV_STAGES];
    logic          rdy     [rsg_pkg::DIV_STAGES+1];

    // ready chain from the output back to the input
    always_comb
    begin
        rdy[rsg_pkg::DIV_STAGES] = res_ready;
        for (int k = LAST; k >= 0; k--)
            rdy[k] = !v_reg[k] || rdy[k+1];
    end

    assign num_ready = rdy[0];

    // stage inputs: first stage starts with the full numerator
    always_comb
    begin
        st_in[0].rem = num.num;
        st_in[0].q   = '0;
        st_in[0].d   = num.d;
        v_in[0]      = num_valid;
        for (int k = 1; k < rsg_pkg::DIV_STAGES; k++)
        begin
            st_in[k] = st_reg[k-1];
            v_in[k]  = v_reg[k-1];
        end
    end

    // compare and subtract against the shifted divisor
    always_comb
    begin
        logic [rsg_pkg::NUM_W-1:0] trial;
        for (int k = 0; k < rsg_pkg::DIV_STAGES; k++)
        begin
            st_next[k] = st_in[k];
            for (int j = 0; j < rsg_pkg::DIV_BITS; j++)
            begin
                trial = rsg_pkg::NUM_W'(st_in[k].d)
                        << (rsg_pkg::Q_W - 1 - k * rsg_pkg::DIV_BITS - j);
                for (int ch = 0; ch < rsg_pkg::N_CHAN; ch++)
                begin
                    if (st_next[k].rem[ch] >= trial)
                    begin
                        st_next[k].rem[ch] = st_next[k].rem[ch] - trial;
                        st_next[k].q[ch][rsg_pkg::Q_W - 1 - k * rsg_pkg::DIV_BITS - j] = 1'b1;
                    end
                end
            end
        end
    end

    // valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < rsg_pkg::DIV_STAGES; k++)
                v_reg[k] <= 1'b0;
        end
        else
        begin
            for (int k = 0; k < rsg_pkg::DIV_STAGES; k++)
                if (rdy[k])
                    v_reg[k] <= v_in[k];
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < rsg_pkg::DIV_STAGES; k++)
            if (rdy[k] && v_in[k])
                st_reg[k] <= st_next[k];
    end

    assign res_valid = v_reg[LAST];
    assign res       = st_reg[LAST];

    // first stage has only resolved its own quotient bits
    `ASSERT_ALWAYS(a_first_stage_low_q, v_reg[0] |-> (st_reg[0].q[rsg_pkg::CH_RED][rsg_pkg::Q_W-rsg_pkg::DIV_BITS-1:0] == '0 && st_reg[0].q[rsg_pkg::CH_GREEN][rsg_pkg::Q_W-rsg_pkg::DIV_BITS-1:0] == '0 && st_reg[0].q[rsg_pkg::CH_BLUE][rsg_pkg::Q_W-rsg_pkg::DIV_BITS-1:0] == '0), "quotient bits set ahead of their stage")
    // final remainder is below the divisor on every channel
    `ASSERT_ALWAYS(a_final_rem_below_d, v_reg[LAST] |-> (st_reg[LAST].rem[rsg_pkg::CH_RED] < rsg_pkg::NUM_W'(st_reg[LAST].d) && st_reg[LAST].rem[rsg_pkg::CH_GREEN] < rsg_pkg::NUM_W'(st_reg[LAST].d) && st_reg[LAST].rem[rsg_pkg::CH_BLUE] < rsg_pkg::NUM_W'(st_reg[LAST].d)), "divider remainder not reduced")
    // a stalled first stage keeps its word
    `ASSERT_NEXT(a_first_stage_hold, v_reg[0] && !rdy[1], v_reg[0] && $stable(st_reg[0]), "stalled divider word lost")

endmodule

>>> hw/rtl/rgb565_three_stop_gradient_unit.sv
// top level of the three-stop rgb565 gradient unit
// stages: clamp, segment select, products, sum, then three divider stages
// throughput: one word per cycle while the output is not stalled; each pipeline stage holds its word while stalled
// reset: pipeline empties, breakpoints load 0 / 50 / 100 and all colors load 0
// config writes take effect at once and are always ready
module rgb565_three_stop_gradient_unit #(
    parameter int LEVEL_WIDTH = 16
) (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [rsg_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [15:0]                    cfg_data,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  logic [LEVEL_WIDTH-1:0]         level,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [rsg_pkg::COLOR_W-1:0]    color_out
);

    rsg_pkg::cfg_t cfg_reg;
    logic          seg_valid;
    logic          seg_ready;
    rsg_pkg::seg_t seg;
    logic          num_valid;
    logic          num_ready;
    rsg_pkg::num_t num;
    rsg_pkg::div_t res;

    // configuration registers, unknown indexes ignored
    assign cfg_ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.range_low    <= rsg_pkg::RESET_RANGE_LOW;
            cfg_reg.range_mid    <= rsg_pkg::RESET_RANGE_MID;
            cfg_reg.range_high   <= rsg_pkg::RESET_RANGE_HIGH;
            cfg_reg.color_start  <= rsg_pkg::RESET_COLOR;
            cfg_reg.color_middle <= rsg_pkg::RESET_COLOR;
            cfg_reg.color_end    <= rsg_pkg::RESET_COLOR;
        end
        else if (cfg_valid)
        begin
            case (cfg_index)
                rsg_pkg::REG_RANGE_LOW:    cfg_reg.range_low    <= cfg_data;
                rsg_pkg::REG_RANGE_MID:    cfg_reg.range_mid    <= cfg_data;
                rsg_pkg::REG_RANGE_HIGH:   cfg_reg.range_high   <= cfg_data;
                rsg_pkg::REG_COLOR_START:  cfg_reg.color_start  <= cfg_data;
                rsg_pkg::REG_COLOR_MIDDLE: cfg_reg.color_middle <= cfg_data;
                rsg_pkg::REG_COLOR_END:    cfg_reg.color_end    <= cfg_data;
                default: ;
            endcase
        end
    end

    // clamp and segment select
    rsg_front #(
        .LEVEL_WIDTH (LEVEL_WIDTH)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .level     (level),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg)
    );

    // weighted sums
    rsg_mac u_mac (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (seg_valid),
        .seg_ready (seg_ready),
        .seg       (seg),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num)
    );

    // division by the segment width
    rsg_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .num_valid (num_valid),
        .num_ready (num_ready),
        .num       (num),
        .res_valid (out_valid),
        .res_ready (out_ready),
        .res       (res)
    );

    // pack the quotients into rgb565
    assign color_out = {res.q[rsg_pkg::CH_RED][4:0],
                        res.q[rsg_pkg::CH_GREEN][5:0],
                        res.q[rsg_pkg::CH_BLUE][4:0]};

endmodule
